### src/pdfa_pkg.sv
// Package for the programmable DFA runner: field widths, action codes and
// default sizes. Used by pdfa_ram and programmable_dfa_runner.
`default_nettype none

package pdfa_pkg;

	localparam int STATE_W = 7;
	localparam int SYM_W = 8;
	localparam int ACT_W = 3;

	// Table entry: valid bit above the target state
	localparam int ENTRY_W = STATE_W + 1;

	localparam logic [SYM_W-1:0] SYM_BASE = 8'h61;

	localparam int DEF_STATE_COUNT = 128;
	localparam int DEF_ALPHABET = 26;
	localparam int DEF_DEPTH = DEF_STATE_COUNT * DEF_ALPHABET;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 3'd0,
		ACT_FINAL = 3'd1,
		ACT_RESTART = 3'd2,
		ACT_LOAD = 3'd3,
		ACT_FEED = 3'd4
	} act_t;

endpackage

`default_nettype wire

### src/programmable_dfa_runner.sv
// Top level of the programmable DFA runner: control sequencer, state registers,
// transition table and final-mark RAMs. Depends on pdfa_pkg and pdfa_ram.
`default_nettype none

// Each input transaction gives one output transaction. Inside the block an item
// goes through accept and transition-table read, next-state selection and
// final-mark read, then loading the output register; a stalled output holds
// it in that last step. After reset a clearing pass writes every table entry
// (one entry per cycle, 3328 by default) before s_tready first rises;
// cfg writes are taken during it. s_tuser bits [2:0] carry the action code.
module programmable_dfa_runner #(
	parameter int STATE_COUNT = pdfa_pkg::DEF_STATE_COUNT,
	parameter int ALPHABET = pdfa_pkg::DEF_ALPHABET
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [pdfa_pkg::STATE_W-1:0]     cfg_wdata,  // start_state
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [6:0] state_id, [14:7] symbol, [21:15] target_state, [22] final_value
	input  wire logic [pdfa_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire logic [pdfa_pkg::ACT_W-1:0]       s_tuser,    // [2:0] action
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [6:0] now_state, [7] is_dead, [8] is_accepting, [9] bad_write
	output logic      [pdfa_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int DEPTH = STATE_COUNT * ALPHABET;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
	localparam int SW = pdfa_pkg::STATE_W;
	localparam int EW = pdfa_pkg::ENTRY_W;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE = 4'b0010,
		ST_LOOK = 4'b0100,
		ST_MARK = 4'b1000
	} fsm_t;

	fsm_t st_q;
	logic [AW-1:0] clr_cnt_q;
	logic [SW-1:0] start_q;
	logic [SW-1:0] cur_state_q;
	logic dead_q;

	pdfa_pkg::act_t act_s1;
	logic [SW-1:0] sid_s1;
	logic [SW-1:0] tgt_s1;
	logic sym_ok_s1;
	logic row_ok_s1;
	logic [AW-1:0] addr_s1;

	logic bad_s2;
	logic mark_ok_s2;

	logic out_valid_q;
	logic [pdfa_pkg::M_TDATA_W-1:0] out_data_q;

	// input field split
	logic [SW-1:0] in_sid;
	logic [pdfa_pkg::SYM_W-1:0] in_sym;
	logic [SW-1:0] in_tgt;
	logic in_fval;
	pdfa_pkg::act_t in_act;
	logic [pdfa_pkg::SYM_W-1:0] sym_off;
	logic in_sym_ok;
	logic [SW-1:0] row_state;
	logic in_row_ok;
	logic accept;
	logic out_free;

	// RAM ports
	logic tab_we;
	logic [AW-1:0] tab_waddr;
	logic [EW-1:0] tab_wdata;
	logic [AW-1:0] tab_raddr;
	logic [EW-1:0] tab_rdata;
	logic mrk_we;
	logic [MW-1:0] mrk_waddr;
	logic mrk_wdata;
	logic [MW-1:0] mrk_raddr;
	logic mrk_rdata;

	// next-state selection in ST_LOOK
	logic [SW-1:0] nxt_state;
	logic nxt_dead;
	logic nxt_bad;
	logic look_wr;
	logic ent_valid;
	logic [SW-1:0] ent_tgt;

	assign in_sid = s_tdata[6:0];
	assign in_sym = s_tdata[14:7];
	assign in_tgt = s_tdata[21:15];
	assign in_fval = s_tdata[22];
	assign in_act = pdfa_pkg::act_t'(s_tuser);

	assign sym_off = in_sym - pdfa_pkg::SYM_BASE;
	assign in_sym_ok = (in_sym >= pdfa_pkg::SYM_BASE) && (32'(sym_off) < ALPHABET);
	// a write indexes the row of its source state, a feed the current state
	assign row_state = (in_act == pdfa_pkg::ACT_WRITE) ? in_sid : cur_state_q;
	assign in_row_ok = 32'(row_state) < STATE_COUNT;

	assign s_tready = (st_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign tab_raddr = AW'(AW'(row_state) * AW'(ALPHABET) + AW'(sym_off));
	assign ent_valid = tab_rdata[EW-1];
	assign ent_tgt = tab_rdata[SW-1:0];

	always_comb begin
		nxt_state = cur_state_q;
		nxt_dead = dead_q;
		nxt_bad = 1'b0;
		look_wr = 1'b0;
		case (act_s1)
			pdfa_pkg::ACT_WRITE: begin
				nxt_bad = !sym_ok_s1;
				look_wr = sym_ok_s1 && row_ok_s1 && !ent_valid;
			end
			pdfa_pkg::ACT_RESTART: begin
				nxt_state = start_q;
				nxt_dead = 1'b0;
			end
			pdfa_pkg::ACT_LOAD: begin
				nxt_state = sid_s1;
				nxt_dead = 1'b0;
			end
			pdfa_pkg::ACT_FEED: begin
				if (!dead_q) begin
					if (sym_ok_s1 && row_ok_s1 && ent_valid) begin
						nxt_state = ent_tgt;
					end else begin
						nxt_dead = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// clearing pass owns the write ports until it is done
	always_comb begin
		if (st_q == ST_CLEAR) begin
			tab_we = 1'b1;
			tab_waddr = clr_cnt_q;
			tab_wdata = '0;
			mrk_we = 32'(clr_cnt_q) < STATE_COUNT;
			mrk_waddr = MW'(clr_cnt_q);
			mrk_wdata = 1'b0;
		end else begin
			tab_we = (st_q == ST_LOOK) && look_wr;
			tab_waddr = addr_s1;
			tab_wdata = {1'b1, tgt_s1};
			mrk_we = accept && (in_act == pdfa_pkg::ACT_FINAL) &&
				(32'(in_sid) < STATE_COUNT);
			mrk_waddr = MW'(in_sid);
			mrk_wdata = in_fval;
		end
	end

	// keep reading the settled state while the result waits for the output
	assign mrk_raddr = (st_q == ST_LOOK) ? MW'(nxt_state) : MW'(cur_state_q);

	pdfa_ram #(
		.DEPTH(DEPTH),
		.WIDTH(EW)
	) u_tab_ram (
		.clk(clk),
		.we(tab_we),
		.waddr(tab_waddr),
		.wdata(tab_wdata),
		.raddr(tab_raddr),
		.rdata(tab_rdata)
	);

	pdfa_ram #(
		.DEPTH(STATE_COUNT),
		.WIDTH(1)
	) u_mrk_ram (
		.clk(clk),
		.we(mrk_we),
		.waddr(mrk_waddr),
		.wdata(mrk_wdata),
		.raddr(mrk_raddr),
		.rdata(mrk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_cnt_q <= '0;
			start_q <= '0;
			cur_state_q <= '0;
			dead_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_wdata;
			end
			if (st_q == ST_MARK && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == AW'(DEPTH - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						st_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					cur_state_q <= nxt_state;
					dead_q <= nxt_dead;
					st_q <= ST_MARK;
				end
				ST_MARK: begin
					// hold the result until the output register frees up
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= in_act;
			sid_s1 <= in_sid;
			tgt_s1 <= in_tgt;
			sym_ok_s1 <= in_sym_ok;
			row_ok_s1 <= in_row_ok;
			addr_s1 <= tab_raddr;
		end
		if (st_q == ST_LOOK) begin
			bad_s2 <= nxt_bad;
			mark_ok_s2 <= 32'(nxt_state) < STATE_COUNT;
		end
		if (st_q == ST_MARK && out_free) begin
			out_data_q <= {6'b0, bad_s2, !dead_q && mark_ok_s2 && mrk_rdata, dead_q,
				cur_state_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR) |-> !s_tready)
		else $error("input accepted during clearing pass");

	a_dead_from_feed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dead_q) |-> $past(st_q == ST_LOOK && act_s1 == pdfa_pkg::ACT_FEED))
		else $error("dead flag set outside a feed");

	a_state_from_look: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cur_state_q) |-> $past(st_q == ST_LOOK))
		else $error("current state changed outside lookup");

	a_accept_not_dead: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[8] && m_tdata[7]))
		else $error("result both accepting and dead");

endmodule

`default_nettype wire

### src/pdfa_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on pdfa_pkg for default sizes.
`default_nettype none

module pdfa_ram #(
	parameter int DEPTH = pdfa_pkg::DEF_DEPTH,
	parameter int WIDTH = pdfa_pkg::ENTRY_W,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for programmable_dfa_runner: a class mirrors the
// automaton and checks each output transaction. Depends on pdfa_pkg and the RTL.
`default_nettype none

module tb_top;

	localparam int SW = pdfa_pkg::STATE_W;
	localparam int YW = pdfa_pkg::SYM_W;
	localparam int AW = pdfa_pkg::ACT_W;
	localparam int NUM_ST = pdfa_pkg::DEF_STATE_COUNT;
	localparam int ALPHA = pdfa_pkg::DEF_ALPHABET;
	localparam int DEPTH = pdfa_pkg::DEF_DEPTH;
	localparam logic [YW-1:0] SYM_BASE = pdfa_pkg::SYM_BASE;
	localparam int QUIET_LIMIT = 20000;
	localparam int PHASE_ITEMS = 335;

	// action codes with no function in the block
	localparam logic [AW-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [AW-1:0] ACT_SPARE_MID = 3'd6;
	localparam logic [AW-1:0] ACT_SPARE_LAST = 3'd7;

	// bit order matches m_tdata: now_state lowest, bad_write highest
	typedef struct packed {
		logic bad_write;
		logic is_accepting;
		logic is_dead;
		logic [SW-1:0] now_state;
	} dfa_report_t;

	class dfa_tracker;
		bit edge_valid[DEPTH];
		bit [SW-1:0] edge_target[DEPTH];
		bit final_mark[NUM_ST];
		bit [SW-1:0] start_state;
		bit [SW-1:0] cur_state;
		bit dead;
		dfa_report_t pending_reports[$];
		int errors;
		int items;
		int feeds;
		int writes;
		int rejected_writes;
		int results;
		int dead_seen;
		int accepting_seen;

		function new();
			start_state = '0;
			cur_state = '0;
			dead = 1'b0;
		endfunction

		function void set_start(bit [SW-1:0] value);
			start_state = value;
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction

		function void report(string msg);
			errors++;
			$display("MISMATCH: %s", msg);
		endfunction

		// Advance the mirror by one input transaction and queue its report.
		function void note_item(logic [AW-1:0] act, logic [SW-1:0] sid,
				logic [YW-1:0] sym, logic [SW-1:0] tgt, logic fval);
			dfa_report_t r;
			bit in_alpha;
			int idx;
			int slot;
			in_alpha = (sym >= SYM_BASE) && (int'(sym) < int'(SYM_BASE) + ALPHA);
			idx = int'(sym) - int'(SYM_BASE);
			r = '0;
			items++;
			case (act)
				pdfa_pkg::ACT_WRITE: begin
					writes++;
					if (!in_alpha) begin
						r.bad_write = 1'b1;
						rejected_writes++;
					end else if (int'(sid) < NUM_ST) begin
						slot = int'(sid) * ALPHA + idx;
						// first write wins
						if (!edge_valid[slot]) begin
							edge_valid[slot] = 1'b1;
							edge_target[slot] = tgt;
						end
					end
				end
				pdfa_pkg::ACT_FINAL: begin
					if (int'(sid) < NUM_ST)
						final_mark[sid] = fval;
				end
				pdfa_pkg::ACT_RESTART: begin
					cur_state = start_state;
					dead = 1'b0;
				end
				pdfa_pkg::ACT_LOAD: begin
					cur_state = sid;
					dead = 1'b0;
				end
				pdfa_pkg::ACT_FEED: begin
					feeds++;
					if (!dead) begin
						if (in_alpha && int'(cur_state) < NUM_ST) begin
							slot = int'(cur_state) * ALPHA + idx;
							if (edge_valid[slot])
								cur_state = edge_target[slot];
							else
								dead = 1'b1;
						end else begin
							dead = 1'b1;
						end
					end
				end
				default: ;
			endcase
			r.now_state = cur_state;
			r.is_dead = dead;
			r.is_accepting = !dead && int'(cur_state) < NUM_ST && final_mark[cur_state];
			pending_reports.push_back(r);
		endfunction

		function void check_report(dfa_report_t got);
			dfa_report_t want;
			results++;
			if (got.is_dead === 1'b1)
				dead_seen++;
			if (got.is_accepting === 1'b1)
				accepting_seen++;
			if (pending_reports.size() == 0) begin
				report($sformatf("unexpected result #%0d: state %0d dead %b acc %b bad %b",
					results, got.now_state, got.is_dead, got.is_accepting,
					got.bad_write));
				return;
			end
			want = pending_reports.pop_front();
			if (got.now_state !== want.now_state || got.is_dead !== want.is_dead ||
					got.is_accepting !== want.is_accepting ||
					got.bad_write !== want.bad_write)
				report($sformatf("result #%0d: state %0d/%0d dead %b/%b acc %b/%b bad %b/%b",
					results, got.now_state, want.now_state, got.is_dead, want.is_dead,
					got.is_accepting, want.is_accepting, got.bad_write, want.bad_write));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [SW-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// [6:0] state_id, [14:7] symbol, [21:15] target_state, [22] final_value
	logic [pdfa_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic [AW-1:0] s_tuser = '0;  // [2:0] action
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [6:0] now_state, [7] is_dead, [8] is_accepting, [9] bad_write
	logic [pdfa_pkg::M_TDATA_W-1:0] m_tdata;

	dfa_tracker tracker;
	bit idle_on = 1'b0;
	int items_sent = 0;
	int quiet_cycles = 0;
	int start_settings = 0;
	int rx_stall = 0;

	programmable_dfa_runner dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: random stall bursts while idling is enabled.
	always @(posedge clk) begin
		if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rx_stall <= $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Monitor both sides; sampled values are the ones before this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_item(s_tuser, s_tdata[6:0], s_tdata[14:7], s_tdata[21:15],
					s_tdata[22]);
			if (m_tvalid && m_tready)
				tracker.check_report(m_tdata[9:0]);
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
		$display("programmable_dfa_runner regression: fail");
		$finish;
	end

	// Call right after a rising edge; returns right after the accepting edge.
	task automatic send_item(input logic [AW-1:0] act, input logic [SW-1:0] sid,
			input logic [YW-1:0] sym, input logic [SW-1:0] tgt, input logic fval);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, fval, tgt, sym, sid};
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Drain the block, then write the start state while it sits idle.
	task automatic write_start(input logic [SW-1:0] value);
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_start(value);
		start_settings++;
	endtask

	function automatic logic [SW-1:0] any_state();
		return SW'($urandom_range(0, NUM_ST - 1));
	endfunction

	// Mostly a small cluster of states so that feeds walk real paths.
	function automatic logic [SW-1:0] near_state();
		if ($urandom_range(0, 4) == 0)
			return any_state();
		return SW'($urandom_range(0, 15));
	endfunction

	function automatic logic [YW-1:0] pick_symbol();
		if ($urandom_range(0, 7) == 0)
			return YW'($urandom_range(0, 255));
		return SYM_BASE + YW'($urandom_range(0, ALPHA - 1));
	endfunction

	function automatic logic [YW-1:0] any_byte();
		return YW'($urandom_range(0, 255));
	endfunction

	task automatic run_directed();
		// empty table: first feed kills the run, a second one keeps it dead
		send_item(pdfa_pkg::ACT_FEED, 7'd0, SYM_BASE, 7'd0, 1'b0);
		send_item(pdfa_pkg::ACT_FEED, 7'd0, SYM_BASE + 8'd1, 7'd0, 1'b0);
		send_item(pdfa_pkg::ACT_RESTART, 7'd0, 8'd0, 7'd0, 1'b0);
		send_item(pdfa_pkg::ACT_WRITE, 7'd127, SYM_BASE + 8'd25, 7'd0, 1'b0);
		// repeated write to a valid entry is dropped
		send_item(pdfa_pkg::ACT_WRITE, 7'd127, SYM_BASE + 8'd25, 7'd5, 1'b1);
		// symbols just outside the alphabet and the byte extremes
		send_item(pdfa_pkg::ACT_WRITE, 7'd0, SYM_BASE - 8'd1, 7'd127, 1'b0);
		send_item(pdfa_pkg::ACT_WRITE, 7'd0, SYM_BASE + 8'd26, 7'd1, 1'b0);
		send_item(pdfa_pkg::ACT_WRITE, 7'd0, 8'h00, 7'd1, 1'b0);
		send_item(pdfa_pkg::ACT_WRITE, 7'd0, 8'hFF, 7'd127, 1'b1);
		send_item(pdfa_pkg::ACT_WRITE, 7'd0, SYM_BASE, 7'd127, 1'b0);
		send_item(pdfa_pkg::ACT_FINAL, 7'd0, 8'd0, 7'd0, 1'b1);
		send_item(pdfa_pkg::ACT_FINAL, 7'd127, 8'hFF, 7'd127, 1'b1);
		send_item(pdfa_pkg::ACT_FEED, 7'd0, SYM_BASE + 8'd25, 7'd0, 1'b0);
		send_item(pdfa_pkg::ACT_FEED, 7'd127, SYM_BASE, 7'd127, 1'b1);
		send_item(pdfa_pkg::ACT_FINAL, 7'd127, 8'd0, 7'd0, 1'b0);
		send_item(pdfa_pkg::ACT_FEED, 7'd0, 8'hFF, 7'd0, 1'b0);
		send_item(pdfa_pkg::ACT_LOAD, 7'd0, 8'd0, 7'd0, 1'b0);
		send_item(pdfa_pkg::ACT_FEED, 7'd0, SYM_BASE - 8'd1, 7'd0, 1'b0);
		send_item(ACT_SPARE_FIRST, 7'd127, 8'hFF, 7'd127, 1'b1);
		send_item(ACT_SPARE_MID, 7'd0, SYM_BASE, 7'd3, 1'b0);
		send_item(ACT_SPARE_LAST, 7'd55, 8'hAA, 7'd42, 1'b1);
		send_item(pdfa_pkg::ACT_LOAD, 7'd127, 8'd0, 7'd0, 1'b0);
		send_item(pdfa_pkg::ACT_FEED, 7'd0, SYM_BASE, 7'd0, 1'b0);
		send_item(pdfa_pkg::ACT_RESTART, 7'd127, 8'hFF, 7'd127, 1'b1);
	endtask

	task automatic random_item();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// one word: restart or load, then a run of symbols
			if ($urandom_range(0, 3) == 0)
				send_item(pdfa_pkg::ACT_LOAD, near_state(), any_byte(), any_state(),
					1'($urandom));
			else
				send_item(pdfa_pkg::ACT_RESTART, any_state(), any_byte(), any_state(),
					1'($urandom));
			n = $urandom_range(1, 8);
			repeat (n)
				send_item(pdfa_pkg::ACT_FEED, any_state(), pick_symbol(), any_state(),
					1'($urandom));
		end else if (pick < 65) begin
			send_item(pdfa_pkg::ACT_WRITE, near_state(), pick_symbol(), near_state(),
				1'($urandom));
		end else if (pick < 78) begin
			send_item(pdfa_pkg::ACT_FINAL, near_state(), any_byte(), any_state(),
				1'($urandom));
		end else if (pick < 83) begin
			send_item(AW'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), any_state(),
				any_byte(), any_state(), 1'($urandom));
		end else if (pick < 90) begin
			send_item(pdfa_pkg::ACT_FEED, any_state(), any_byte(), any_state(),
				1'($urandom));
		end else if (pick < 95) begin
			send_item(pdfa_pkg::ACT_RESTART, any_state(), any_byte(), any_state(),
				1'($urandom));
		end else begin
			send_item(pdfa_pkg::ACT_LOAD, any_state(), any_byte(), any_state(),
				1'($urandom));
		end
	endtask

	initial begin
		logic [SW-1:0] starts[5];
		int target;
		tracker = new();
		starts[0] = 7'd0;
		starts[1] = any_state();
		starts[2] = 7'd127;
		starts[3] = SW'($urandom_range(0, 15));
		starts[4] = 7'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		write_start(7'd127);
		idle_on = 1'b1;
		run_directed();
		for (int p = 0; p < 5; p++) begin
			write_start(starts[p]);
			// last phase runs with both sides at full rate
			idle_on = (p != 4);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				random_item();
		end
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered %0d items (%0d feeds, %0d writes, %0d rejected), %0d start values",
			tracker.items, tracker.feeds, tracker.writes, tracker.rejected_writes,
			start_settings);
		$display("checked %0d results: %0d dead, %0d accepting, %0d mismatches",
			tracker.results, tracker.dead_seen, tracker.accepting_seen, tracker.errors);
		if (tracker.errors == 0)
			$display("programmable_dfa_runner regression: pass");
		else
			$display("programmable_dfa_runner regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
